// ===== design/wltqs_pkg.sv =====
`default_nettype none
package wltqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int LEVELS      = 3;

    localparam int TASK_ID_W   = 8;
    localparam int PRIO_W      = 2;
    localparam int RAND_W      = 16;
    localparam int LEVEL_W     = 2;
    localparam int WEIGHT_W    = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_MID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_LOW  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_HIGH_RST = 4'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MID_RST  = 4'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_LOW_RST  = 4'd1;

    localparam logic [LEVEL_W-1:0] LVL_HIGH = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd1;

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_SELECT  = 1'b1;

    typedef struct packed {
        logic load_in;
        logic weigh;
        logic div_step;
        logic pick;
        logic enq_commit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_select;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/wltqs_in_if.sv =====
`default_nettype none
interface wltqs_in_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic [wltqs_pkg::TASK_ID_W-1:0]  task_id;
    logic [wltqs_pkg::PRIO_W-1:0]     priority_req;
    logic [wltqs_pkg::RAND_W-1:0]     lottery_draw;

    modport source (output valid, mode, task_id, priority_req, lottery_draw, input ready);
    modport sink (input valid, mode, task_id, priority_req, lottery_draw, output ready);
endinterface
`default_nettype wire

// ===== design/wltqs_out_if.sv =====
`default_nettype none
interface wltqs_out_if;
    logic                             valid;
    logic                             ready;
    logic                             grant_valid;
    logic [wltqs_pkg::TASK_ID_W-1:0]  grant_id;
    logic [wltqs_pkg::LEVEL_W-1:0]    grant_level;
    logic                             overflow;

    modport source (output valid, grant_valid, grant_id, grant_level, overflow, input ready);
    modport sink (input valid, grant_valid, grant_id, grant_level, overflow, output ready);
endinterface
`default_nettype wire

// ===== design/wltqs_ctrl.sv =====
`default_nettype none
module wltqs_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wltqs_pkg::t_dp_stat     i_stat,
    output wltqs_pkg::t_dp_cmd      o_cmd
);

    localparam int DIV_CNT_W = $clog2(wltqs_pkg::RAND_W);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WEIGH  = 6'b000010,
        S_ENQ    = 6'b000100,
        S_DIVIDE = 6'b001000,
        S_PICK   = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_WEIGH;
                end
            end
            S_WEIGH: begin
                o_cmd.weigh = 1'b1;
                n_div_cnt   = '0;
                n_state     = i_stat.is_select ? S_DIVIDE : S_ENQ;
            end
            S_ENQ: begin
                if (i_stat.out_free) begin
                    o_cmd.enq_commit = 1'b1;
                    o_cmd.load_out   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(wltqs_pkg::RAND_W - 1)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== design/wltqs_dp.sv =====
`default_nettype none
module wltqs_dp #(
    parameter int QUEUE_DEPTH = wltqs_pkg::QUEUE_DEPTH,
    parameter int ID_WIDTH    = wltqs_pkg::ID_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_mode,
    input  wire logic [wltqs_pkg::TASK_ID_W-1:0]     i_task_id,
    input  wire logic [wltqs_pkg::PRIO_W-1:0]        i_priority_req,
    input  wire logic [wltqs_pkg::RAND_W-1:0]        i_lottery_draw,
    input  wire logic                                i_cfg_we,
    input  wire logic [wltqs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [wltqs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wltqs_pkg::t_dp_cmd                       i_cmd,
    output wltqs_pkg::t_dp_stat                      o_stat,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic                                     o_grant_valid,
    output logic [wltqs_pkg::TASK_ID_W-1:0]          o_grant_id,
    output logic [wltqs_pkg::LEVEL_W-1:0]            o_grant_level,
    output logic                                     o_overflow
);

    localparam int LEVELS  = wltqs_pkg::LEVELS;
    localparam int LEVEL_W = wltqs_pkg::LEVEL_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int BAND_W  = CNT_W + wltqs_pkg::WEIGHT_W;
    localparam int TOT_W   = BAND_W + 2;
    localparam int MEM_N   = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_N);
    localparam int RAND_W  = wltqs_pkg::RAND_W;

    logic [wltqs_pkg::WEIGHT_W-1:0] r_weight [LEVELS];

    logic                 r_mode;
    logic [ID_WIDTH-1:0]  r_task_id;
    logic [LEVEL_W-1:0]   r_level;
    logic [RAND_W-1:0]    r_rand;

    logic [PTR_W-1:0]     r_head  [LEVELS];
    logic [PTR_W-1:0]     r_tail  [LEVELS];
    logic [CNT_W-1:0]     r_count [LEVELS];

    logic [BAND_W-1:0]    r_band_h, r_band_m;
    logic [TOT_W-1:0]     r_total, r_rem;

    logic [ID_WIDTH-1:0]  r_mem [MEM_N];
    logic [ID_WIDTH-1:0]  r_rd_data;
    logic                 r_grant;
    logic [LEVEL_W-1:0]   r_glevel;

    logic                 r_out_valid;
    logic                 r_grant_valid;
    logic [wltqs_pkg::TASK_ID_W-1:0] r_grant_id;
    logic [LEVEL_W-1:0]   r_grant_level;
    logic                 r_overflow;

    logic [LEVEL_W-1:0]   in_level;
    logic [BAND_W-1:0]    band_h, band_m, band_l;
    logic [TOT_W-1:0]     total;
    logic [TOT_W:0]       rem_shift;
    logic [TOT_W:0]       rem_next;
    logic [TOT_W-1:0]     band_hm;
    logic [LEVEL_W-1:0]   sel_level;
    logic                 grant;
    logic                 full;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;

    always_comb begin
        if (i_priority_req == wltqs_pkg::PRIO_HIGH) begin
            in_level = wltqs_pkg::LVL_HIGH;
        end else if (i_priority_req == wltqs_pkg::PRIO_MID) begin
            in_level = wltqs_pkg::LVL_MID;
        end else begin
            in_level = wltqs_pkg::LVL_LOW;
        end
    end

    assign band_h = BAND_W'(r_count[0]) * BAND_W'(r_weight[0]);
    assign band_m = BAND_W'(r_count[1]) * BAND_W'(r_weight[1]);
    assign band_l = BAND_W'(r_count[2]) * BAND_W'(r_weight[2]);
    assign total  = TOT_W'(band_h) + TOT_W'(band_m) + TOT_W'(band_l);

    // One quotient bit per cycle; the remainder stays below the total whenever the total is nonzero.
    assign rem_shift = {r_rem, r_rand[RAND_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, r_total}) ? rem_shift - {1'b0, r_total} : rem_shift;

    assign band_hm = TOT_W'(r_band_h) + TOT_W'(r_band_m);

    always_comb begin
        if (r_rem < TOT_W'(r_band_h)) begin
            sel_level = wltqs_pkg::LVL_HIGH;
        end else if (r_rem < band_hm) begin
            sel_level = wltqs_pkg::LVL_MID;
        end else begin
            sel_level = wltqs_pkg::LVL_LOW;
        end
    end

    assign grant   = (r_total != '0) && (r_count[sel_level] != '0);
    assign full    = (r_count[r_level] == CNT_W'(QUEUE_DEPTH));
    assign wr_addr = ADDR_W'(r_level) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[r_level]);
    assign rd_addr = ADDR_W'(sel_level) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[sel_level]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight[0] <= wltqs_pkg::WEIGHT_HIGH_RST;
            r_weight[1] <= wltqs_pkg::WEIGHT_MID_RST;
            r_weight[2] <= wltqs_pkg::WEIGHT_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wltqs_pkg::REG_WEIGHT_HIGH: r_weight[0] <= i_cfg_wdata;
                wltqs_pkg::REG_WEIGHT_MID:  r_weight[1] <= i_cfg_wdata;
                wltqs_pkg::REG_WEIGHT_LOW:  r_weight[2] <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_mode;
            r_task_id <= ID_WIDTH'(i_task_id);
            r_level   <= in_level;
            r_rand    <= i_lottery_draw;
        end else if (i_cmd.div_step) begin
            r_rand    <= r_rand << 1;
        end
        if (i_cmd.weigh) begin
            r_band_h <= band_h;
            r_band_m <= band_m;
            r_total  <= total;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem    <= TOT_W'(rem_next);
        end
        if (i_cmd.pick) begin
            r_grant  <= grant;
            r_glevel <= sel_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_cmd.enq_commit && !full) begin
            r_tail[r_level]  <= (r_tail[r_level] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                '0 : r_tail[r_level] + 1'b1;
            r_count[r_level] <= r_count[r_level] + 1'b1;
        end else if (i_cmd.pick && grant) begin
            r_head[sel_level]  <= (r_head[sel_level] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : r_head[sel_level] + 1'b1;
            r_count[sel_level] <= r_count[sel_level] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_commit && !full) begin
            r_mem[wr_addr] <= r_task_id;
        end
        if (i_cmd.pick) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_mode == wltqs_pkg::MODE_SELECT) begin
                r_grant_valid <= r_grant;
                r_grant_id    <= r_grant ? wltqs_pkg::TASK_ID_W'(r_rd_data) : '0;
                r_grant_level <= r_grant ? r_glevel : wltqs_pkg::LVL_HIGH;
                r_overflow    <= 1'b0;
            end else begin
                r_grant_valid <= 1'b0;
                r_grant_id    <= '0;
                r_grant_level <= wltqs_pkg::LVL_HIGH;
                r_overflow    <= full;
            end
        end
    end

    assign o_stat.is_select = (r_mode == wltqs_pkg::MODE_SELECT);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_grant_valid = r_grant_valid;
    assign o_grant_id    = r_grant_id;
    assign o_grant_level = r_grant_level;
    assign o_overflow    = r_overflow;

endmodule
`default_nettype wire

// ===== design/weighted_lottery_three_queue_scheduler_top.sv =====
// An enqueue item passes through the weigh and enqueue states; a select item through weigh, divide, pick and finish.
// One item at a time; the enqueue and finish states wait while the output register is still full.
// A select item runs the 16-step bit-serial remainder of the random value by the total.
// Reset is synchronous and active low: weights return to 3, 2, 1, pointers and counts clear.
// The queue store is not cleared; only written entries are ever popped.
`default_nettype none
module weighted_lottery_three_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = wltqs_pkg::QUEUE_DEPTH,
    parameter int ID_WIDTH    = wltqs_pkg::ID_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    wltqs_in_if.sink                                 i_in,
    wltqs_out_if.source                              o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [wltqs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [wltqs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    wltqs_pkg::t_dp_cmd  w_cmd;
    wltqs_pkg::t_dp_stat w_stat;
    logic                w_in_ready;

    wltqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wltqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_in.mode),
        .i_task_id      (i_in.task_id),
        .i_priority_req (i_in.priority_req),
        .i_lottery_draw (i_in.lottery_draw),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_grant_valid  (o_out.grant_valid),
        .o_grant_id     (o_out.grant_id),
        .o_grant_level  (o_out.grant_level),
        .o_overflow     (o_out.overflow)
    );

    assign i_in.ready = w_in_ready;

    // Only one item is in flight, so the block is busy right after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in flight");

    a_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.grant_valid) |->
        (!o_out.overflow && (o_out.grant_level == wltqs_pkg::LVL_HIGH ||
         o_out.grant_level == wltqs_pkg::LVL_MID || o_out.grant_level == wltqs_pkg::LVL_LOW)))
        else $error("grant result with bad level or overflow set");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.grant_valid) |->
        (o_out.grant_id == '0 && o_out.grant_level == wltqs_pkg::LVL_HIGH))
        else $error("result without grant carries nonzero grant fields");

endmodule
`default_nettype wire

// ===== tb/sv/wltqs_grant_checker.sv =====
`timescale 1ns / 1ps
module wltqs_grant_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wltqs_in_if                               in_ch,
    wltqs_out_if                              out_ch,
    input  logic                              i_cfg_we,
    input  logic [wltqs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wltqs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                                o_pending,
    output int                                o_fail_count
);

    typedef struct packed {
        logic                            grant_valid;
        logic [wltqs_pkg::TASK_ID_W-1:0] grant_id;
        logic [wltqs_pkg::LEVEL_W-1:0]   grant_level;
        logic                            overflow;
    } t_grant;

    t_grant                          expected_grants[$];
    logic [wltqs_pkg::WEIGHT_W-1:0]  lvl_weight [wltqs_pkg::LEVELS];
    logic [wltqs_pkg::TASK_ID_W-1:0] slot_ids [wltqs_pkg::LEVELS][wltqs_pkg::QUEUE_DEPTH];
    int                              head_idx [wltqs_pkg::LEVELS];
    int                              tail_idx [wltqs_pkg::LEVELS];
    int                              occupancy [wltqs_pkg::LEVELS];
    int                              mismatches = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
        mismatches++;
    endtask

    // Updates the queue state and returns the grant that the item must produce.
    function automatic t_grant predict_grant(input logic m,
                                             input logic [wltqs_pkg::TASK_ID_W-1:0] id,
                                             input logic [wltqs_pkg::PRIO_W-1:0] pr,
                                             input logic [wltqs_pkg::RAND_W-1:0] rv);
        t_grant g;
        int     lvl;
        int     band_high;
        int     band_mid;
        int     total;
        int     pick;
        g = '0;
        if (m == wltqs_pkg::MODE_ENQUEUE) begin
            if (pr == wltqs_pkg::PRIO_HIGH)
                lvl = int'(wltqs_pkg::LVL_HIGH);
            else if (pr == wltqs_pkg::PRIO_MID)
                lvl = int'(wltqs_pkg::LVL_MID);
            else
                lvl = int'(wltqs_pkg::LVL_LOW);
            if (occupancy[lvl] >= wltqs_pkg::QUEUE_DEPTH) begin
                g.overflow = 1'b1;
            end else begin
                slot_ids[lvl][tail_idx[lvl]] = id;
                tail_idx[lvl] = (tail_idx[lvl] + 1) % wltqs_pkg::QUEUE_DEPTH;
                occupancy[lvl]++;
            end
        end else begin
            band_high = occupancy[wltqs_pkg::LVL_HIGH] * int'(lvl_weight[wltqs_pkg::LVL_HIGH]);
            band_mid  = occupancy[wltqs_pkg::LVL_MID] * int'(lvl_weight[wltqs_pkg::LVL_MID]);
            total     = band_high + band_mid +
                        occupancy[wltqs_pkg::LVL_LOW] * int'(lvl_weight[wltqs_pkg::LVL_LOW]);
            if (total != 0) begin
                pick = int'(rv) % total;
                if (pick < band_high)
                    lvl = int'(wltqs_pkg::LVL_HIGH);
                else if (pick < band_high + band_mid)
                    lvl = int'(wltqs_pkg::LVL_MID);
                else
                    lvl = int'(wltqs_pkg::LVL_LOW);
                if (occupancy[lvl] != 0) begin
                    g.grant_valid = 1'b1;
                    g.grant_id    = slot_ids[lvl][head_idx[lvl]];
                    g.grant_level = lvl[wltqs_pkg::LEVEL_W-1:0];
                    head_idx[lvl] = (head_idx[lvl] + 1) % wltqs_pkg::QUEUE_DEPTH;
                    occupancy[lvl]--;
                end
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            lvl_weight[wltqs_pkg::LVL_HIGH] = wltqs_pkg::WEIGHT_HIGH_RST;
            lvl_weight[wltqs_pkg::LVL_MID]  = wltqs_pkg::WEIGHT_MID_RST;
            lvl_weight[wltqs_pkg::LVL_LOW]  = wltqs_pkg::WEIGHT_LOW_RST;
            for (int l = 0; l < wltqs_pkg::LEVELS; l++) begin
                head_idx[l]  = 0;
                tail_idx[l]  = 0;
                occupancy[l] = 0;
            end
            expected_grants.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wltqs_pkg::REG_WEIGHT_HIGH: lvl_weight[wltqs_pkg::LVL_HIGH] = i_cfg_wdata;
                    wltqs_pkg::REG_WEIGHT_MID:  lvl_weight[wltqs_pkg::LVL_MID]  = i_cfg_wdata;
                    wltqs_pkg::REG_WEIGHT_LOW:  lvl_weight[wltqs_pkg::LVL_LOW]  = i_cfg_wdata;
                    default: ;
                endcase
            end
            // The result leaving now always belongs to an older item than one entering now.
            if (out_ch.valid && out_ch.ready) begin
                if (expected_grants.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 1);
                end else begin
                    want = expected_grants.pop_front();
                    if (out_ch.grant_valid !== want.grant_valid)
                        report_mismatch("grant_valid", int'(want.grant_valid),
                                        int'(out_ch.grant_valid));
                    if (out_ch.grant_id !== want.grant_id)
                        report_mismatch("grant_id", int'(want.grant_id),
                                        int'(out_ch.grant_id));
                    if (out_ch.grant_level !== want.grant_level)
                        report_mismatch("grant_level", int'(want.grant_level),
                                        int'(out_ch.grant_level));
                    if (out_ch.overflow !== want.overflow)
                        report_mismatch("overflow", int'(want.overflow),
                                        int'(out_ch.overflow));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_grants.push_back(predict_grant(in_ch.mode, in_ch.task_id,
                                                        in_ch.priority_req,
                                                        in_ch.lottery_draw));
            end
        end
        o_pending    <= expected_grants.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 6;
    localparam int IDLE_PCT     = 36;
    localparam int DRAIN_CYCLES = 25;
    localparam int STEADY_FIRST = 600;
    localparam int STEADY_LAST  = 800;

    localparam logic [wltqs_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [wltqs_pkg::PRIO_W-1:0]      PRIO_LOW     = 2'd2;
    localparam logic [wltqs_pkg::PRIO_W-1:0]      PRIO_LOW_ALT = 2'd3;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [wltqs_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [wltqs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                              steady;
    int                                cycles = 0;
    int                                items_sent = 0;
    int                                pending;
    int                                fail_count;

    wltqs_in_if  in_ch ();
    wltqs_out_if out_ch ();

    always #1 i_clk = ~i_clk;

    weighted_lottery_three_queue_scheduler_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    wltqs_grant_checker u_grant_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [wltqs_pkg::RAND_W-1:0] random_draw();
        // Small draws land near the band edges more often.
        if ($urandom_range(0, 3) == 0)
            return wltqs_pkg::RAND_W'($urandom_range(0, 800));
        return wltqs_pkg::RAND_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(input logic m, input logic [wltqs_pkg::TASK_ID_W-1:0] id,
                             input logic [wltqs_pkg::PRIO_W-1:0] pr,
                             input logic [wltqs_pkg::RAND_W-1:0] rv);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= m;
        in_ch.task_id      <= id;
        in_ch.priority_req <= pr;
        in_ch.lottery_draw <= rv;
        steady             <= (items_sent >= STEADY_FIRST && items_sent < STEADY_LAST);
        items_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Weights change only once every outstanding item has come back.
    task automatic set_weights(input logic [wltqs_pkg::WEIGHT_W-1:0] w_high,
                               input logic [wltqs_pkg::WEIGHT_W-1:0] w_mid,
                               input logic [wltqs_pkg::WEIGHT_W-1:0] w_low);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= wltqs_pkg::REG_WEIGHT_HIGH;
        i_cfg_wdata <= w_high;
        @(posedge i_clk);
        i_cfg_index <= wltqs_pkg::REG_WEIGHT_MID;
        i_cfg_wdata <= w_mid;
        @(posedge i_clk);
        i_cfg_index <= wltqs_pkg::REG_WEIGHT_LOW;
        i_cfg_wdata <= w_low;
        @(posedge i_clk);
        i_cfg_index <= REG_UNMAPPED;
        i_cfg_wdata <= wltqs_pkg::CFG_DATA_W'($urandom_range(0, 15));
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One burst: a run of enqueues to one queue, a run of selects, or a random mix.
    task automatic run_sequence();
        int                           kind;
        int                           n;
        logic [wltqs_pkg::PRIO_W-1:0] pr;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(1, 20);
        pr   = wltqs_pkg::PRIO_W'($urandom_range(0, 3));
        for (int k = 0; k < n; k++) begin
            if (kind < 4)
                send_item(wltqs_pkg::MODE_ENQUEUE,
                          wltqs_pkg::TASK_ID_W'($urandom_range(0, 255)), pr,
                          wltqs_pkg::RAND_W'($urandom_range(0, 65535)));
            else if (kind < 8)
                send_item(wltqs_pkg::MODE_SELECT,
                          wltqs_pkg::TASK_ID_W'($urandom_range(0, 255)),
                          wltqs_pkg::PRIO_W'($urandom_range(0, 3)), random_draw());
            else
                send_item(1'($urandom_range(0, 1)),
                          wltqs_pkg::TASK_ID_W'($urandom_range(0, 255)),
                          wltqs_pkg::PRIO_W'($urandom_range(0, 3)), random_draw());
        end
    endtask

    initial begin
        int phase_end;
        in_ch.valid        = 1'b0;
        in_ch.mode         = wltqs_pkg::MODE_ENQUEUE;
        in_ch.task_id      = '0;
        in_ch.priority_req = wltqs_pkg::PRIO_HIGH;
        in_ch.lottery_draw = '0;
        out_ch.ready       = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = wltqs_pkg::REG_WEIGHT_HIGH;
        i_cfg_wdata        = '0;
        steady             = 1'b0;
        i_rst_n            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset weights 3, 2, 1: select when empty, one id high, one mid, two low.
        send_item(wltqs_pkg::MODE_SELECT, 8'hFF, PRIO_LOW_ALT, 16'hFFFF);
        send_item(wltqs_pkg::MODE_ENQUEUE, 8'h00, wltqs_pkg::PRIO_HIGH, 16'h0000);
        send_item(wltqs_pkg::MODE_ENQUEUE, 8'hFF, wltqs_pkg::PRIO_MID, 16'hFFFF);
        send_item(wltqs_pkg::MODE_ENQUEUE, 8'hA5, PRIO_LOW, 16'h5555);
        send_item(wltqs_pkg::MODE_ENQUEUE, 8'h5A, PRIO_LOW_ALT, 16'hAAAA);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_HIGH, 16'h0000);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_HIGH, 16'hFFFF);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_MID, 16'h0001);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, PRIO_LOW, 16'h0000);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_HIGH, 16'h8000);

        // All weights zero: a queue holds an id, yet the total is zero.
        set_weights(4'd0, 4'd0, 4'd0);
        send_item(wltqs_pkg::MODE_ENQUEUE, 8'h3C, wltqs_pkg::PRIO_HIGH, 16'h0000);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_HIGH, 16'hFFFF);
        set_weights(4'd15, 4'd15, 4'd15);
        send_item(wltqs_pkg::MODE_SELECT, 8'h00, wltqs_pkg::PRIO_HIGH, 16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_weights(4'd15, 4'd15, 4'd15);
                1: set_weights(4'd0, 4'd15, 4'd1);
                2: set_weights(4'd1, 4'd0, 4'd15);
                3: set_weights(4'd15, 4'd1, 4'd0);
                default: set_weights(wltqs_pkg::WEIGHT_W'($urandom_range(0, 15)),
                                     wltqs_pkg::WEIGHT_W'($urandom_range(0, 15)),
                                     wltqs_pkg::WEIGHT_W'($urandom_range(0, 15)));
            endcase
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end)
                run_sequence();
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/wltqs_pkg.sv
design/wltqs_in_if.sv
design/wltqs_out_if.sv
design/wltqs_ctrl.sv
design/wltqs_dp.sv
design/weighted_lottery_three_queue_scheduler_top.sv
tb/sv/wltqs_grant_checker.sv
tb/sv/tb_top.sv
